// ===== rtl/gsl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsl_pkg: shared types and constants of the G-code style lexer
// Span length limit, style codes, dialect codes and the per-byte run bundle
// passed from the lexer front to the span back end.
// ----------------------------------------------------------------------------
package gsl_pkg;

    // Longest span, in bytes
    localparam int MAX_SPAN  = 4095;
    localparam int LEN_W     = $clog2(MAX_SPAN + 1);
    localparam int RUN_LEN_W = 12;

    // Bundle queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef logic [7:0]           byte_t;
    typedef logic [1:0]           dialect_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [RUN_LEN_W-1:0] run_len_t;
    typedef logic [QPTR_W-1:0]    qptr_t;
    typedef logic [QCNT_W-1:0]    qcnt_t;

    localparam len_t MAX_LEN = len_t'(MAX_SPAN);

    // Dialect codes
    localparam dialect_t DIALECT_SEMI  = 2'd0;
    localparam dialect_t DIALECT_PAREN = 2'd1;
    localparam dialect_t DIALECT_OHDR  = 2'd2;
    localparam dialect_t DIALECT_RESET = DIALECT_PAREN;

    typedef enum logic [2:0] {
        STY_TEXT    = 3'd0,
        STY_COMMENT = 3'd1,
        STY_HEADER  = 3'd2,
        STY_LABEL   = 3'd3,
        STY_MCODE   = 3'd4,
        STY_TOOL    = 3'd5
    } style_t;

    // One run of bytes of a known style; sat marks a saturated pending run
    typedef struct packed {
        logic   valid;
        style_t style;
        len_t   len;
        logic   sat;
    } run_t;

    // Work caused by one byte: up to two runs, then an optional end-of-text flush
    typedef struct packed {
        run_t r0;
        run_t r1;
        logic last;
    } bundle_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic  full;
        logic  empty;
        qcnt_t level;
    } q_stat_t;

endpackage
`default_nettype wire

// ===== rtl/gsl_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsl_if: channel interfaces of the G-code style lexer
// Text byte channel, span result channel and dialect configuration channel.
// ----------------------------------------------------------------------------
interface gsl_text_if;
    logic           valid;
    logic           ready;
    gsl_pkg::byte_t ch;
    logic           end_of_text;

    modport source (output valid, ch, end_of_text, input ready);
    modport sink   (input valid, ch, end_of_text, output ready);
endinterface

interface gsl_span_if;
    logic              valid;
    logic              ready;
    gsl_pkg::style_t   style;
    gsl_pkg::run_len_t run_length;
    logic              overflow;
    logic              last_span;

    modport source (output valid, style, run_length, overflow, last_span, input ready);
    modport sink   (input valid, style, run_length, overflow, last_span, output ready);
endinterface

interface gsl_cfg_if;
    logic              valid;
    logic              ready;
    gsl_pkg::dialect_t dialect;

    modport source (output valid, dialect, input ready);
    modport sink   (input valid, dialect, output ready);
endinterface
`default_nettype wire

// ===== rtl/gsl_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsl_queue: bundle queue between lexer front and span back end
// Small circular buffer; the head entry is visible while the queue is not empty.
// ----------------------------------------------------------------------------
module gsl_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gsl_pkg::bundle_t  push_data,
    input  logic              pop,
    output gsl_pkg::bundle_t  head,
    output gsl_pkg::q_stat_t  stat
);

    localparam gsl_pkg::qptr_t LAST_SLOT = gsl_pkg::qptr_t'(gsl_pkg::QDEPTH - 1);
    localparam gsl_pkg::qcnt_t FULL_CNT  = gsl_pkg::qcnt_t'(gsl_pkg::QDEPTH);

    gsl_pkg::bundle_t slots [gsl_pkg::QDEPTH];

    gsl_pkg::qptr_t wr_ptr_reg, wr_ptr_next;
    gsl_pkg::qptr_t rd_ptr_reg, rd_ptr_next;
    gsl_pkg::qcnt_t count_reg, count_next;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed bundles
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = slots[rd_ptr_reg];
    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign stat.level = count_reg;

endmodule
`default_nettype wire

// ===== rtl/gsl_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsl_front: lexer front end
// Takes one text byte per cycle while the queue has room, tracks the line phase
// and pending runs, and pushes the runs each byte resolves as one bundle into the queue.
// ----------------------------------------------------------------------------
module gsl_front
(
    input  logic              clk,
    input  logic              rst_n,
    gsl_text_if.sink          text,
    input  gsl_pkg::dialect_t dialect,
    input  gsl_pkg::q_stat_t  q_stat,
    output logic              q_push,
    output gsl_pkg::bundle_t  q_data
);

    localparam gsl_pkg::byte_t CH_PCT    = 8'h25;
    localparam gsl_pkg::byte_t CH_O      = 8'h4F;
    localparam gsl_pkg::byte_t CH_N      = 8'h4E;
    localparam gsl_pkg::byte_t CH_M      = 8'h4D;
    localparam gsl_pkg::byte_t CH_T      = 8'h54;
    localparam gsl_pkg::byte_t CH_D      = 8'h44;
    localparam gsl_pkg::byte_t CH_SEMI   = 8'h3B;
    localparam gsl_pkg::byte_t CH_LPAR   = 8'h28;
    localparam gsl_pkg::byte_t CH_RPAR   = 8'h29;
    localparam gsl_pkg::byte_t CH_LF     = 8'h0A;
    localparam gsl_pkg::byte_t CH_DOT    = 8'h2E;
    localparam gsl_pkg::byte_t CH_PLUS   = 8'h2B;
    localparam gsl_pkg::byte_t CH_MINUS  = 8'h2D;
    localparam gsl_pkg::byte_t CH_SPACE  = 8'h20;
    localparam gsl_pkg::byte_t CH_TAB    = 8'h09;
    localparam gsl_pkg::byte_t CH_0      = 8'h30;
    localparam gsl_pkg::byte_t CH_9      = 8'h39;
    localparam gsl_pkg::byte_t CH_UA     = 8'h41;
    localparam gsl_pkg::byte_t CH_UZ     = 8'h5A;
    localparam gsl_pkg::byte_t CH_LA     = 8'h61;
    localparam gsl_pkg::byte_t CH_LZ     = 8'h7A;
    localparam gsl_pkg::byte_t UPPER_MSK = 8'hDF;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_OCAND,
        PH_HDR,
        PH_PRE,
        PH_BODY,
        PH_PAREN,
        PH_SEMI,
        PH_WORD
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic            started_reg, started_next;
    logic            prev_letter_reg, prev_letter_next;
    gsl_pkg::style_t word_style_reg, word_style_next;
    gsl_pkg::len_t   pend_len_reg, pend_len_next;
    logic            pend_sat_reg, pend_sat_next;

    logic            accept;
    logic            is_lf, is_blank, ch_letter, ch_num, is_sign;
    logic            pend_open;
    gsl_pkg::len_t   grow_len;
    logic            grow_sat;
    gsl_pkg::style_t cand;
    logic            do_body;

    function automatic gsl_pkg::run_t make_run(gsl_pkg::style_t s, gsl_pkg::len_t n,
                                                logic sat);
        gsl_pkg::run_t r;
        r.valid = (n != '0) || sat;
        r.style = s;
        r.len   = n;
        r.sat   = sat;
        return r;
    endfunction

    function automatic gsl_pkg::run_t one_byte(gsl_pkg::style_t s);
        gsl_pkg::run_t r;
        r.valid = 1'b1;
        r.style = s;
        r.len   = gsl_pkg::len_t'(1);
        r.sat   = 1'b0;
        return r;
    endfunction

    // Style a pending run takes when the line ends in the given phase
    function automatic gsl_pkg::style_t eol_style(phase_t ph, logic started);
        gsl_pkg::style_t s;
        case (ph)
            PH_LEAD:  s = started ? gsl_pkg::STY_TEXT : gsl_pkg::STY_COMMENT;
            PH_OCAND: s = gsl_pkg::STY_COMMENT;
            default:  s = gsl_pkg::STY_TEXT;
        endcase
        return s;
    endfunction

    assign accept     = text.valid && text.ready;
    assign text.ready = !q_stat.full;
    assign q_push     = accept;

    // Classify the byte
    assign is_lf     = (text.ch == CH_LF);
    assign is_blank  = text.ch inside {CH_SPACE, CH_TAB};
    assign ch_letter = text.ch inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ]};
    assign ch_num    = text.ch inside {[CH_0:CH_9]};
    assign is_sign   = text.ch inside {CH_DOT, CH_PLUS, CH_MINUS};

    always_comb
    begin
        case (text.ch & UPPER_MSK)
            CH_N:       cand = gsl_pkg::STY_LABEL;
            CH_M:       cand = gsl_pkg::STY_MCODE;
            CH_T, CH_D: cand = gsl_pkg::STY_TOOL;
            default:    cand = gsl_pkg::STY_TEXT;
        endcase
    end

    // Grow the pending run, saturating at the span limit
    assign pend_open = (pend_len_reg != '0) || pend_sat_reg;
    assign grow_len  = (pend_len_reg < gsl_pkg::MAX_LEN) ? pend_len_reg + 1'b1 : pend_len_reg;
    assign grow_sat  = pend_sat_reg || (pend_len_reg == gsl_pkg::MAX_LEN);

    // Lex one byte into a bundle and the next state
    always_comb
    begin
        phase_next       = phase_reg;
        started_next     = started_reg;
        prev_letter_next = prev_letter_reg;
        word_style_next  = word_style_reg;
        pend_len_next    = pend_len_reg;
        pend_sat_next    = pend_sat_reg;
        q_data           = '0;
        do_body          = 1'b0;

        if (is_lf)
        begin
            q_data.r0        = make_run(eol_style(phase_reg, started_reg),
                                        pend_len_reg, pend_sat_reg);
            pend_len_next    = '0;
            pend_sat_next    = 1'b0;
            q_data.r1        = one_byte(gsl_pkg::STY_TEXT);
            phase_next       = PH_LEAD;
            prev_letter_next = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_LEAD:
                begin
                    if (is_blank)
                    begin
                        pend_len_next = grow_len;
                        pend_sat_next = grow_sat;
                    end
                    else if (text.ch == CH_PCT)
                    begin
                        q_data.r0     = make_run(gsl_pkg::STY_HEADER, pend_len_reg, pend_sat_reg);
                        pend_len_next = '0;
                        pend_sat_next = 1'b0;
                        q_data.r1     = one_byte(gsl_pkg::STY_HEADER);
                        started_next  = 1'b1;
                        phase_next    = PH_HDR;
                    end
                    else if (!started_reg && dialect == gsl_pkg::DIALECT_OHDR
                             && text.ch == CH_O)
                    begin
                        pend_len_next = grow_len;
                        pend_sat_next = grow_sat;
                        phase_next    = PH_OCAND;
                    end
                    else if (!started_reg)
                    begin
                        q_data.r0     = make_run(gsl_pkg::STY_COMMENT, pend_len_reg, pend_sat_reg);
                        pend_len_next = '0;
                        pend_sat_next = 1'b0;
                        q_data.r1     = one_byte(gsl_pkg::STY_COMMENT);
                        phase_next    = PH_PRE;
                    end
                    else
                    begin
                        q_data.r0     = make_run(gsl_pkg::STY_TEXT, pend_len_reg, pend_sat_reg);
                        pend_len_next = '0;
                        pend_sat_next = 1'b0;
                        do_body       = 1'b1;
                    end
                end
                PH_OCAND:
                begin
                    pend_len_next = '0;
                    pend_sat_next = 1'b0;
                    if (ch_num)
                    begin
                        q_data.r0    = make_run(gsl_pkg::STY_HEADER, pend_len_reg, pend_sat_reg);
                        q_data.r1    = one_byte(gsl_pkg::STY_HEADER);
                        started_next = 1'b1;
                        phase_next   = PH_HDR;
                    end
                    else
                    begin
                        q_data.r0  = make_run(gsl_pkg::STY_COMMENT, pend_len_reg, pend_sat_reg);
                        q_data.r1  = one_byte(gsl_pkg::STY_COMMENT);
                        phase_next = PH_PRE;
                    end
                end
                PH_HDR:
                begin
                    q_data.r1 = one_byte(gsl_pkg::STY_HEADER);
                end
                PH_PRE, PH_SEMI:
                begin
                    q_data.r1 = one_byte(gsl_pkg::STY_COMMENT);
                end
                PH_PAREN:
                begin
                    q_data.r1 = one_byte(gsl_pkg::STY_COMMENT);
                    if (text.ch == CH_RPAR)
                    begin
                        phase_next = PH_BODY;
                    end
                end
                PH_WORD:
                begin
                    if (ch_num)
                    begin
                        q_data.r0     = make_run(word_style_reg, pend_len_reg, pend_sat_reg);
                        pend_len_next = '0;
                        pend_sat_next = 1'b0;
                        q_data.r1     = one_byte(word_style_reg);
                    end
                    else if (is_sign)
                    begin
                        if (pend_open)
                        begin
                            pend_len_next = grow_len;
                            pend_sat_next = grow_sat;
                        end
                        else
                        begin
                            q_data.r1 = one_byte(word_style_reg);
                        end
                    end
                    else
                    begin
                        q_data.r0     = make_run(gsl_pkg::STY_TEXT, pend_len_reg, pend_sat_reg);
                        pend_len_next = '0;
                        pend_sat_next = 1'b0;
                        do_body       = 1'b1;
                    end
                end
                default:
                begin
                    do_body = 1'b1;
                end
            endcase

            // Body byte: comment opener, word letter or plain text
            if (do_body)
            begin
                if (dialect != gsl_pkg::DIALECT_SEMI && text.ch == CH_LPAR)
                begin
                    q_data.r1  = one_byte(gsl_pkg::STY_COMMENT);
                    phase_next = PH_PAREN;
                end
                else if (dialect == gsl_pkg::DIALECT_SEMI && text.ch == CH_SEMI)
                begin
                    q_data.r1  = one_byte(gsl_pkg::STY_COMMENT);
                    phase_next = PH_SEMI;
                end
                else if (ch_letter)
                begin
                    phase_next = PH_WORD;
                    if (!prev_letter_reg && cand != gsl_pkg::STY_TEXT)
                    begin
                        word_style_next = cand;
                        pend_len_next   = gsl_pkg::len_t'(1);
                        pend_sat_next   = 1'b0;
                    end
                    else
                    begin
                        word_style_next = gsl_pkg::STY_TEXT;
                        q_data.r1       = one_byte(gsl_pkg::STY_TEXT);
                    end
                end
                else
                begin
                    q_data.r1  = one_byte(gsl_pkg::STY_TEXT);
                    phase_next = PH_BODY;
                end
            end

            prev_letter_next = ch_letter;
        end

        // End of text: resolve what is still pending, flush, start over
        if (text.end_of_text)
        begin
            if (pend_len_next != '0 || pend_sat_next)
            begin
                q_data.r1 = make_run(eol_style(phase_next, started_next),
                                     pend_len_next, pend_sat_next);
            end
            q_data.last      = 1'b1;
            phase_next       = PH_LEAD;
            started_next     = 1'b0;
            prev_letter_next = 1'b0;
            word_style_next  = gsl_pkg::STY_TEXT;
            pend_len_next    = '0;
            pend_sat_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LEAD;
            started_reg     <= 1'b0;
            prev_letter_reg <= 1'b0;
            word_style_reg  <= gsl_pkg::STY_TEXT;
            pend_len_reg    <= '0;
            pend_sat_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            started_reg     <= started_next;
            prev_letter_reg <= prev_letter_next;
            word_style_reg  <= word_style_next;
            pend_len_reg    <= pend_len_next;
            pend_sat_reg    <= pend_sat_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/gsl_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsl_back: span back end
// Walks the runs of the head bundle one per cycle unless a span waits for the
// output register, merges them into the open span and emits closed spans through it.
// ----------------------------------------------------------------------------
module gsl_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  gsl_pkg::bundle_t  head,
    input  gsl_pkg::q_stat_t  q_stat,
    output logic              q_pop,
    gsl_span_if.source        span
);

    typedef enum logic [1:0] {
        OP_R0,
        OP_R1,
        OP_LAST,
        OP_NONE
    } op_t;

    logic            done0_reg, done0_next;
    logic            done1_reg, done1_next;

    gsl_pkg::style_t open_style_reg, open_style_next;
    gsl_pkg::len_t   open_len_reg, open_len_next;
    logic            open_sat_reg, open_sat_next;

    logic              span_valid_reg, span_valid_next;
    gsl_pkg::style_t   span_style_reg;
    gsl_pkg::run_len_t span_len_reg;
    logic              span_ovf_reg;
    logic              span_last_reg;

    op_t                 op;
    gsl_pkg::run_t       cur;
    logic                more;
    logic                emit;
    gsl_pkg::style_t     em_style;
    gsl_pkg::len_t       em_len;
    logic                em_sat;
    logic                em_last;
    logic [gsl_pkg::LEN_W:0] sum;
    logic                out_free;
    logic                step;

    // Pick the next unfinished step of the head bundle
    always_comb
    begin
        if (head.r0.valid && !done0_reg)
        begin
            op = OP_R0;
        end
        else if (head.r1.valid && !done1_reg)
        begin
            op = OP_R1;
        end
        else if (head.last)
        begin
            op = OP_LAST;
        end
        else
        begin
            op = OP_NONE;
        end
    end

    assign cur  = (op == OP_R0) ? head.r0 : head.r1;
    assign more = (op == OP_R0) ? (head.r1.valid || head.last)
                : (op == OP_R1) ? head.last : 1'b0;
    assign sum  = {1'b0, open_len_reg} + {1'b0, cur.len};

    // Merge a run into the open span, closing it on change or when full, and flush it at end of text
    always_comb
    begin
        emit            = 1'b0;
        em_style        = open_style_reg;
        em_len          = open_len_reg;
        em_sat          = open_sat_reg;
        em_last         = 1'b0;
        open_style_next = open_style_reg;
        open_len_next   = open_len_reg;
        open_sat_next   = open_sat_reg;
        case (op)
            OP_R0, OP_R1:
            begin
                if (cur.sat)
                begin
                    emit            = (open_len_reg != '0);
                    open_style_next = cur.style;
                    open_len_next   = cur.len;
                    open_sat_next   = 1'b1;
                end
                else if (cur.len != '0)
                begin
                    open_style_next = cur.style;
                    open_sat_next   = 1'b0;
                    if (open_len_reg != '0
                        && (open_style_reg != cur.style || open_sat_reg))
                    begin
                        emit          = 1'b1;
                        open_len_next = cur.len;
                    end
                    else if (open_len_reg == gsl_pkg::MAX_LEN)
                    begin
                        emit          = 1'b1;
                        open_len_next = cur.len;
                    end
                    else if (sum > {1'b0, gsl_pkg::MAX_LEN})
                    begin
                        emit          = 1'b1;
                        em_style      = cur.style;
                        em_len        = gsl_pkg::MAX_LEN;
                        em_sat        = 1'b0;
                        open_len_next = gsl_pkg::len_t'(sum - {1'b0, gsl_pkg::MAX_LEN});
                    end
                    else
                    begin
                        open_len_next = gsl_pkg::len_t'(sum);
                    end
                end
            end
            OP_LAST:
            begin
                emit            = (open_len_reg != '0);
                em_last         = 1'b1;
                open_style_next = gsl_pkg::STY_TEXT;
                open_len_next   = '0;
                open_sat_next   = 1'b0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Hold the step while its span cannot enter the output register
    assign out_free = !span_valid_reg || span.ready;
    assign step     = !q_stat.empty && (!emit || out_free);
    assign q_pop    = step && !more;

    always_comb
    begin
        done0_next = done0_reg;
        done1_next = done1_reg;
        if (step)
        begin
            if (more)
            begin
                done0_next = done0_reg || (op == OP_R0);
                done1_next = done1_reg || (op == OP_R1);
            end
            else
            begin
                done0_next = 1'b0;
                done1_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (step && emit)
        begin
            span_valid_next = 1'b1;
        end
        else if (span.ready)
        begin
            span_valid_next = 1'b0;
        end
        else
        begin
            span_valid_next = span_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done0_reg      <= 1'b0;
            done1_reg      <= 1'b0;
            open_style_reg <= gsl_pkg::STY_TEXT;
            open_len_reg   <= '0;
            open_sat_reg   <= 1'b0;
            span_valid_reg <= 1'b0;
        end
        else
        begin
            done0_reg      <= done0_next;
            done1_reg      <= done1_next;
            span_valid_reg <= span_valid_next;
            if (step)
            begin
                open_style_reg <= open_style_next;
                open_len_reg   <= open_len_next;
                open_sat_reg   <= open_sat_next;
            end
        end
    end

    // Load the span payload
    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            span_style_reg <= em_style;
            span_len_reg   <= gsl_pkg::run_len_t'(em_len);
            span_ovf_reg   <= em_sat;
            span_last_reg  <= em_last;
        end
    end

    assign span.valid      = span_valid_reg;
    assign span.style      = span_style_reg;
    assign span.run_length = span_len_reg;
    assign span.overflow   = span_ovf_reg;
    assign span.last_span  = span_last_reg;

endmodule
`default_nettype wire

// ===== rtl/gcode_style_lexer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcode_style_lexer_core: CNC program text lexer emitting style spans
// Throughput: one text byte per cycle while each byte needs one back-end step
//   and the span sink keeps up; a byte that resolves a pending run, or the
//   end-of-text flush, takes one back-end step per run, absorbed by a
//   four-entry bundle queue. Span path: the bundle of the byte that closes a
//   span is registered in the queue, and the span enters the output register
//   on its back-end step, later while older bundles wait or the sink stalls.
// Reset: dialect 1, empty line state and open span, queue empty, no sweep.
// ----------------------------------------------------------------------------
module gcode_style_lexer_core
(
    input  logic       clk,
    input  logic       rst_n,
    gsl_text_if.sink   text,
    gsl_cfg_if.sink    cfg,
    gsl_span_if.source span
);

    gsl_pkg::dialect_t dialect_reg;
    logic              q_push;
    logic              q_pop;
    gsl_pkg::bundle_t  q_in;
    gsl_pkg::bundle_t  q_head;
    gsl_pkg::q_stat_t  q_stat;

    // Dialect register, written on any configuration transaction
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dialect_reg <= gsl_pkg::DIALECT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            dialect_reg <= cfg.dialect;
        end
    end

    gsl_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text),
        .dialect (dialect_reg),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    gsl_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    gsl_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .q_stat (q_stat),
        .q_pop  (q_pop),
        .span   (span)
    );

    // Queue level stays within its depth and full and empty never coincide
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.level <= gsl_pkg::qcnt_t'(gsl_pkg::QDEPTH)) && !(q_stat.full && q_stat.empty))
        else $error("bundle queue level out of range");

    // The back end never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty bundle queue");

    // A saturated span always carries the full span limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (span.valid && span.overflow) |->
            (span.run_length == gsl_pkg::run_len_t'(gsl_pkg::MAX_SPAN)))
        else $error("overflow span without full length");

    // No empty span leaves the block
    assert property (@(posedge clk) disable iff (!rst_n)
        span.valid |-> ((gsl_pkg::MAX_SPAN >= 4096) || (span.run_length != '0)))
        else $error("zero-length span emitted");

endmodule
`default_nettype wire

// ===== tb/gcode_style_lexer_core_tb.sv =====
// ----------------------------------------------------------------------------
// gcode_style_lexer_core_tb: self-checking bench for the CNC text lexer
// Feeds program text byte by byte through the text channel, keeps its own
// lexer model to predict the style spans, and checks every span transaction
// field by field. Covers a short directed table and random programs in every
// dialect, with random gaps on both channels and a stretch without gaps.
// ----------------------------------------------------------------------------
module gcode_style_lexer_core_tb;
    import gsl_pkg::*;

    // Line phases of the lexer model
    typedef enum logic [2:0] {
        PH_LEAD, PH_OCAND, PH_HDR, PH_PRE, PH_BODY, PH_PAREN, PH_SEMI, PH_WORD
    } line_phase_t;

    typedef struct packed {
        style_t   style;
        run_len_t len;
        logic     ovf;
        logic     last;
    } span_t;

    typedef struct packed {
        byte_t ch;
        logic  eot;
        logic  typed;
        span_t want;
    } text_row_t;

    localparam byte_t    CH_LF  = 8'h0A;
    localparam byte_t    CH_TAB = 8'h09;
    localparam byte_t    CH_SP  = 8'h20;
    // Unused code; the block treats it as parenthesis comments
    localparam dialect_t DIALECT_SPARE = 2'd3;
    localparam int       N_DIRECTED    = 24;
    localparam int       RANDOM_BYTES  = 170;

    logic clk = 1'b0;
    logic rst_n;
    bit   steady;

    gsl_text_if text_ch ();
    gsl_cfg_if  cfg_ch ();
    gsl_span_if span_ch ();

    gcode_style_lexer_core i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_ch),
        .cfg   (cfg_ch),
        .span  (span_ch)
    );

    always #4 clk = ~clk;

    // Lexer model state
    dialect_t    lx_dialect;
    bit          lx_started;
    line_phase_t lx_phase;
    bit          lx_prev_alpha;
    style_t      lx_word_style;
    int          lx_pend_len;
    bit          lx_pend_sat;
    style_t      lx_open_style;
    int          lx_open_len;
    bit          lx_open_sat;
    span_t       step_spans[$];

    // Spans owed by the block, oldest first
    span_t       spans_due[$];

    int          fail_count;
    int          bytes_sent;
    int          random_bytes;
    int          spans_seen;
    int          saturated_seen;
    int          texts_sent;
    bit [3:0]    dialects_hit;
    text_row_t   directed_rows [N_DIRECTED];

    function automatic bit gap_now();
        return $urandom_range(0, 99) < 17;
    endfunction

    function automatic bit letter_byte(byte_t c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit num_byte(byte_t c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void note_fail(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    // ------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------

    // Close the open span and hand it out
    function automatic void close_span(bit last);
        span_t s;
        if (lx_open_len > 0)
        begin
            s.style = lx_open_style;
            s.len   = run_len_t'(lx_open_len);
            s.ovf   = lx_open_sat;
            s.last  = last;
            step_spans.push_back(s);
        end
        lx_open_len = 0;
        lx_open_sat = 1'b0;
    endfunction

    // Merge a run into the open span, splitting at the span limit
    function automatic void add_run(style_t sty, int n, bit sat);
        int left;
        int room;
        int take;
        left = n;
        if (sat)
        begin
            close_span(1'b0);
            lx_open_style = sty;
            lx_open_len   = n;
            lx_open_sat   = 1'b1;
            return;
        end
        if (left == 0)
            return;
        if (lx_open_len > 0 && (lx_open_style != sty || lx_open_sat))
            close_span(1'b0);
        while (left > 0)
        begin
            if (lx_open_len >= MAX_SPAN)
                close_span(1'b0);
            lx_open_style = sty;
            room = MAX_SPAN - lx_open_len;
            take = (left < room) ? left : room;
            lx_open_len += take;
            left -= take;
        end
    endfunction

    function automatic void pend_grow();
        if (lx_pend_len < MAX_SPAN)
            lx_pend_len++;
        else
            lx_pend_sat = 1'b1;
    endfunction

    function automatic bit pend_open();
        return lx_pend_len > 0 || lx_pend_sat;
    endfunction

    // Give the unresolved run its style now that it is known
    function automatic void settle(style_t sty);
        if (pend_open())
            add_run(sty, lx_pend_len, lx_pend_sat);
        lx_pend_len = 0;
        lx_pend_sat = 1'b0;
    endfunction

    function automatic void body_byte(byte_t c);
        bit     paren;
        byte_t  u;
        style_t cand;
        paren = lx_dialect != DIALECT_SEMI;
        if (paren && c == "(")
        begin
            add_run(STY_COMMENT, 1, 1'b0);
            lx_phase = PH_PAREN;
        end
        else if (!paren && c == ";")
        begin
            add_run(STY_COMMENT, 1, 1'b0);
            lx_phase = PH_SEMI;
        end
        else if (letter_byte(c))
        begin
            u = (c >= "a") ? c - 8'd32 : c;
            cand = STY_TEXT;
            if (u == "N")
                cand = STY_LABEL;
            else if (u == "M")
                cand = STY_MCODE;
            else if (u == "T" || u == "D")
                cand = STY_TOOL;
            lx_phase = PH_WORD;
            // A styled word letter waits for its first digit
            if (!lx_prev_alpha && cand != STY_TEXT)
            begin
                lx_word_style = cand;
                lx_pend_len   = 1;
                lx_pend_sat   = 1'b0;
            end
            else
            begin
                lx_word_style = STY_TEXT;
                add_run(STY_TEXT, 1, 1'b0);
            end
        end
        else
        begin
            add_run(STY_TEXT, 1, 1'b0);
            lx_phase = PH_BODY;
        end
    endfunction

    function automatic void line_end();
        if (lx_phase == PH_LEAD)
            settle(lx_started ? STY_TEXT : STY_COMMENT);
        else if (lx_phase == PH_OCAND)
            settle(STY_COMMENT);
        else
            settle(STY_TEXT);
    endfunction

    function automatic void clear_text();
        lx_started    = 1'b0;
        lx_phase      = PH_LEAD;
        lx_prev_alpha = 1'b0;
        lx_word_style = STY_TEXT;
        lx_pend_len   = 0;
        lx_pend_sat   = 1'b0;
        lx_open_style = STY_TEXT;
        lx_open_len   = 0;
        lx_open_sat   = 1'b0;
    endfunction

    // Work out the spans closed by one accepted byte into step_spans
    function automatic void lex_byte(byte_t c, bit eot);
        step_spans.delete();
        if (c == CH_LF)
        begin
            line_end();
            add_run(STY_TEXT, 1, 1'b0);
            lx_phase      = PH_LEAD;
            lx_prev_alpha = 1'b0;
        end
        else
        begin
            case (lx_phase)
                PH_LEAD:
                begin
                    if (c == CH_SP || c == CH_TAB)
                        pend_grow();
                    else if (c == "%")
                    begin
                        settle(STY_HEADER);
                        add_run(STY_HEADER, 1, 1'b0);
                        lx_started = 1'b1;
                        lx_phase   = PH_HDR;
                    end
                    else if (!lx_started && lx_dialect == DIALECT_OHDR && c == "O")
                    begin
                        pend_grow();
                        lx_phase = PH_OCAND;
                    end
                    else if (!lx_started)
                    begin
                        settle(STY_COMMENT);
                        add_run(STY_COMMENT, 1, 1'b0);
                        lx_phase = PH_PRE;
                    end
                    else
                    begin
                        settle(STY_TEXT);
                        body_byte(c);
                    end
                end
                PH_OCAND:
                begin
                    if (num_byte(c))
                    begin
                        settle(STY_HEADER);
                        add_run(STY_HEADER, 1, 1'b0);
                        lx_started = 1'b1;
                        lx_phase   = PH_HDR;
                    end
                    else
                    begin
                        settle(STY_COMMENT);
                        add_run(STY_COMMENT, 1, 1'b0);
                        lx_phase = PH_PRE;
                    end
                end
                PH_HDR:
                    add_run(STY_HEADER, 1, 1'b0);
                PH_PRE, PH_SEMI:
                    add_run(STY_COMMENT, 1, 1'b0);
                PH_PAREN:
                begin
                    add_run(STY_COMMENT, 1, 1'b0);
                    if (c == ")")
                        lx_phase = PH_BODY;
                end
                PH_WORD:
                begin
                    if (num_byte(c))
                    begin
                        if (pend_open())
                            settle(lx_word_style);
                        add_run(lx_word_style, 1, 1'b0);
                    end
                    else if (c == "." || c == "+" || c == "-")
                    begin
                        if (pend_open())
                            pend_grow();
                        else
                            add_run(lx_word_style, 1, 1'b0);
                    end
                    else
                    begin
                        settle(STY_TEXT);
                        body_byte(c);
                    end
                end
                default:
                    body_byte(c);
            endcase
            lx_prev_alpha = letter_byte(c);
        end
        // Flush everything on the final byte of a text
        if (eot)
        begin
            line_end();
            close_span(1'b1);
            clear_text();
        end
    endfunction

    // ------------------------------------------------------------------
    // Random program text
    // ------------------------------------------------------------------

    function automatic byte_t any_print();
        return byte_t'($urandom_range(8'h20, 8'h7E));
    endfunction

    function automatic byte_t digit();
        return byte_t'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic void add_word(ref byte_t t[$]);
        string letters = "NMTDGXnmtdgZ";
        string marks   = ".+-";
        // Sometimes glue a letter in front so the word stays plain text
        if ($urandom_range(0, 4) == 0)
            t.push_back(letters[$urandom_range(0, letters.len() - 1)]);
        t.push_back(letters[$urandom_range(0, letters.len() - 1)]);
        repeat ($urandom_range(0, 2))
            t.push_back(marks[$urandom_range(0, 2)]);
        repeat ($urandom_range(0, 3))
            t.push_back(digit());
        if ($urandom_range(0, 3) == 0)
        begin
            t.push_back(".");
            repeat ($urandom_range(0, 2))
                t.push_back(digit());
        end
    endfunction

    function automatic void add_body_line(ref byte_t t[$]);
        repeat ($urandom_range(0, 2))
            t.push_back(CH_SP);
        repeat ($urandom_range(1, 5))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_word(t);
                4: t.push_back(CH_SP);
                5: t.push_back(CH_TAB);
                6:
                begin
                    t.push_back("(");
                    repeat ($urandom_range(0, 4))
                        t.push_back(any_print());
                    if ($urandom_range(0, 2) != 0)
                        t.push_back(")");
                end
                7:
                begin
                    t.push_back(";");
                    repeat ($urandom_range(0, 3))
                        t.push_back(any_print());
                end
                8: t.push_back(byte_t'($urandom_range(0, 255)));
                default: t.push_back("=");
            endcase
        end
        t.push_back(CH_LF);
    endfunction

    // Build one program: preamble, header line, body lines; or plain noise
    function automatic void build_text(ref byte_t t[$], input dialect_t d, input bit noise);
        t.delete();
        if (noise)
        begin
            repeat ($urandom_range(8, 30))
                t.push_back(($urandom_range(0, 5) == 0) ? CH_LF : byte_t'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2))
        begin
            repeat ($urandom_range(0, 2))
                t.push_back(CH_SP);
            repeat ($urandom_range(1, 6))
                t.push_back(any_print());
            t.push_back(CH_LF);
        end
        repeat ($urandom_range(0, 2))
            t.push_back(($urandom_range(0, 1) != 0) ? CH_SP : CH_TAB);
        if (d == DIALECT_OHDR && $urandom_range(0, 2) != 0)
        begin
            t.push_back("O");
            t.push_back(($urandom_range(0, 3) != 0) ? digit() : any_print());
        end
        else
            t.push_back("%");
        repeat ($urandom_range(0, 4))
            t.push_back(any_print());
        t.push_back(CH_LF);
        repeat ($urandom_range(1, 3))
            add_body_line(t);
        // End some texts in the middle of a word
        if ($urandom_range(0, 2) == 0)
            add_word(t);
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Offer one byte, hold it until accepted, then record what it owes
    task automatic send_byte(input byte_t c, input bit eot, input bit typed, input span_t want);
        while (!steady && gap_now())
        begin
            text_ch.valid <= 1'b0;
            @(negedge clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.ch          <= c;
        text_ch.end_of_text <= eot;
        do
            @(posedge clk);
        while (!text_ch.ready);
        lex_byte(c, eot);
        if (typed)
            spans_due.push_back(want);
        else
        begin
            foreach (step_spans[j])
                spans_due.push_back(step_spans[j]);
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed span has arrived
    task automatic wait_drained(input int settle_cycles);
        text_ch.valid <= 1'b0;
        @(negedge clk);
        while (spans_due.size() != 0)
            @(negedge clk);
        repeat (settle_cycles)
            @(negedge clk);
    endtask

    task automatic send_text(ref byte_t t[$], input bit pause_midway);
        for (int i = 0; i < t.size(); i++)
        begin
            if (pause_midway && i == t.size() / 2)
                wait_drained(0);
            send_byte(t[i], i == t.size() - 1, 1'b0, '0);
        end
        texts_sent++;
    endtask

    task automatic write_dialect(input dialect_t d);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.dialect <= d;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        lx_dialect = d;
        dialects_hit[d] = 1'b1;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Randomly stall the span channel
    always @(negedge clk)
        span_ch.ready <= steady || !gap_now();

    // Check each span transaction against the oldest owed span
    always @(posedge clk)
    begin : check_spans
        span_t got;
        span_t want;
        if (rst_n && span_ch.valid && span_ch.ready)
        begin
            got.style = span_ch.style;
            got.len   = span_ch.run_length;
            got.ovf   = span_ch.overflow;
            got.last  = span_ch.last_span;
            spans_seen++;
            if (got.ovf === 1'b1)
                saturated_seen++;
            if (spans_due.size() == 0)
                note_fail($sformatf("span %0d unexpected: style %0d len %0d ovf %0b last %0b",
                                    spans_seen, got.style, got.len, got.ovf, got.last));
            else
            begin
                want = spans_due.pop_front();
                if (got !== want)
                    note_fail($sformatf({"span %0d: expected style %0d len %0d ovf %0b last %0b,",
                                         " got style %0d len %0d ovf %0b last %0b"},
                                        spans_seen, want.style, want.len, want.ovf, want.last,
                                        got.style, got.len, got.ovf, got.last));
            end
        end
    end

    // Hard stop in case the block hangs
    initial
    begin
        #20_000_000;
        $display("gcode_style_lexer_core_tb: timeout with %0d spans owed", spans_due.size());
        $display("gcode_style_lexer_core_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        byte_t    txt[$];
        dialect_t d;
        dialect_t order [4];
        int       ti;
        int       k;

        text_ch.valid       = 1'b0;
        text_ch.ch          = '0;
        text_ch.end_of_text = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.dialect      = DIALECT_RESET;
        span_ch.ready       = 1'b0;
        rst_n               = 1'b0;
        steady              = 1'b0;
        order = '{DIALECT_SEMI, DIALECT_SPARE, DIALECT_OHDR, DIALECT_PAREN};

        lx_dialect = DIALECT_RESET;
        clear_text();

        // Single-byte texts first: each flushes one span with a known value
        directed_rows = '{
            '{"%",    1'b1, 1'b1, '{STY_HEADER,  12'd1, 1'b0, 1'b1}},
            '{8'h00,  1'b1, 1'b1, '{STY_COMMENT, 12'd1, 1'b0, 1'b1}},
            '{8'hFF,  1'b1, 1'b1, '{STY_COMMENT, 12'd1, 1'b0, 1'b1}},
            '{CH_LF,  1'b1, 1'b1, '{STY_TEXT,    12'd1, 1'b0, 1'b1}},
            // 'O' is no header outside the O-header dialect
            '{"O",    1'b1, 1'b1, '{STY_COMMENT, 12'd1, 1'b0, 1'b1}},
            // Indented header, then label, M-code, comment and tool words
            '{CH_SP,  1'b0, 1'b0, '0},
            '{"%",    1'b0, 1'b0, '0},
            '{CH_LF,  1'b0, 1'b0, '0},
            '{"N",    1'b0, 1'b0, '0},
            '{"1",    1'b0, 1'b0, '0},
            '{CH_SP,  1'b0, 1'b0, '0},
            '{"m",    1'b0, 1'b0, '0},
            '{"3",    1'b0, 1'b0, '0},
            '{"(",    1'b0, 1'b0, '0},
            '{")",    1'b0, 1'b0, '0},
            '{"t",    1'b0, 1'b0, '0},
            '{".",    1'b0, 1'b0, '0},
            '{"5",    1'b0, 1'b0, '0},
            // Word letter right after a letter stays text
            '{"a",    1'b0, 1'b0, '0},
            '{"N",    1'b0, 1'b0, '0},
            '{"5",    1'b0, 1'b0, '0},
            '{CH_SP,  1'b0, 1'b0, '0},
            // Tool letter with a sign but no digit, cut off by end of text
            '{"D",    1'b0, 1'b0, '0},
            '{"+",    1'b1, 1'b0, '0}
        };

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table, under the reset dialect
        for (k = 0; k < N_DIRECTED; k++)
            send_byte(directed_rows[k].ch, directed_rows[k].eot,
                      directed_rows[k].typed, directed_rows[k].want);
        wait_drained(8);

        // Random programs, walking every dialect code first
        ti = 0;
        while (random_bytes < RANDOM_BYTES || ti < 4)
        begin
            d = (ti < 4) ? order[ti] : dialect_t'($urandom_range(0, 3));
            write_dialect(d);
            build_text(txt, d, $urandom_range(0, 5) == 0);
            random_bytes += txt.size();
            // Run two texts with no stalls on either side
            steady = (ti == 2 || ti == 3);
            send_text(txt, ti == 1);
            wait_drained(8);
            ti++;
        end
        steady = 1'b0;

        // Drain and settle
        text_ch.valid <= 1'b0;
        for (k = 0; k < 100000 && spans_due.size() != 0; k++)
            @(negedge clk);
        repeat (16)
            @(negedge clk);
        if (spans_due.size() != 0)
            note_fail($sformatf("%0d spans never arrived", spans_due.size()));

        $display("Run: %0d texts, %0d bytes (%0d random), %0d spans checked, %0d saturated.",
                 texts_sent, bytes_sent, random_bytes, spans_seen, saturated_seen);
        $display("Dialect codes written (3..0): %b; failures: %0d.", dialects_hit, fail_count);
        if (fail_count == 0)
            $display("gcode_style_lexer_core_tb: PASS");
        else
            $display("gcode_style_lexer_core_tb: FAIL");
        $finish;
    end

endmodule
